FILE: rtl/core/seir_pkg.sv
// Shared types, constants and saturation helper for the SEIR Euler step core.
package seir_pkg;

  // Population word width; fractions saturate to at most 32 bits
  localparam int POP_WIDTH = 32;
  localparam int POP_BITS  = (POP_WIDTH < 32) ? POP_WIDTH : 32;
  localparam int PROD_W    = 66;

  typedef logic signed [31:0] frac_t;
  typedef logic        [31:0] q16_t;

  localparam logic signed [PROD_W-1:0] POP_HI =
      (66'sd1 <<< (POP_BITS - 1)) - 66'sd1;
  localparam logic signed [PROD_W-1:0] POP_LO = -POP_HI - 66'sd1;

  // Sum check: 1.0 and 0.001 in Q2.30
  localparam logic signed [34:0] ONE_Q30 = 35'sd1073741824;
  localparam logic signed [34:0] TOL_Q30 = 35'sd1073741;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_SUM    = 3'd1,
    ST_STEP_BIG   = 3'd2,
    ST_FINISHED   = 3'd3,
    ST_NOT_LOADED = 3'd4
  } status_t;

  // Item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_INFECT_RATE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INCUBATION_RATE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_RATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_TIME        = 3'd4;

  // Configuration reset values
  localparam q16_t RST_INFECT_RATE     = 32'd19661;
  localparam q16_t RST_INCUBATION_RATE = 32'd13107;
  localparam q16_t RST_RECOVERY_RATE   = 32'd6554;
  localparam q16_t RST_TIME_STEP       = 32'd6554;
  localparam q16_t RST_END_TIME        = 32'd6553600;

  // Step sequencer: multiplier issue slots and writeback slots
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ISS_I_BETA  = 4'd0;
  localparam logic [STEP_W-1:0] ISS_E_SIGMA = 4'd1;
  localparam logic [STEP_W-1:0] ISS_I_GAMMA = 4'd2;
  localparam logic [STEP_W-1:0] ISS_T1_S    = 4'd3;
  localparam logic [STEP_W-1:0] ISS_DR      = 4'd4;
  localparam logic [STEP_W-1:0] ISS_DI      = 4'd5;
  localparam logic [STEP_W-1:0] ISS_DS      = 4'd6;
  localparam logic [STEP_W-1:0] ISS_DE      = 4'd7;
  localparam logic [STEP_W-1:0] WB_T1       = 4'd1;
  localparam logic [STEP_W-1:0] WB_SE       = 4'd2;
  localparam logic [STEP_W-1:0] WB_GI       = 4'd3;
  localparam logic [STEP_W-1:0] WB_BIS      = 4'd4;
  localparam logic [STEP_W-1:0] WB_REC      = 4'd5;
  localparam logic [STEP_W-1:0] WB_INF      = 4'd6;
  localparam logic [STEP_W-1:0] WB_SUS      = 4'd7;
  localparam logic [STEP_W-1:0] WB_EXP      = 4'd8;
  localparam logic [STEP_W-1:0] STEP_LAST   = WB_EXP;

  // Controller to datapath commands
  typedef struct packed {
    logic              accept;
    logic              calc;
    logic              emit;
    logic [STEP_W-1:0] step_idx;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic go_calc;
  } dp_stat_t;

  // Clamp a wide signed value to the population range
  function automatic frac_t sat_pop(input logic signed [PROD_W-1:0] v);
    frac_t r;
    if (v > POP_HI) begin
      r = POP_HI[31:0];
    end else if (v < POP_LO) begin
      r = POP_LO[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/seir_item_if.sv
// Input item channel: kind plus initial fractions.
interface seir_item_if import seir_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  kind;
  frac_t init_susceptible;
  frac_t init_exposed;
  frac_t init_infected;
  frac_t init_recovered;

  modport source(output valid, kind, init_susceptible, init_exposed, init_infected,
                 init_recovered, input ready);
  modport sink(input valid, kind, init_susceptible, init_exposed, init_infected,
               init_recovered, output ready);
endinterface

FILE: rtl/core/seir_result_if.sv
// Result channel: status, time and the four fractions of one row.
interface seir_result_if import seir_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] status;
  q16_t       sim_time;
  frac_t      susceptible;
  frac_t      exposed;
  frac_t      infected;
  frac_t      recovered;

  modport source(output valid, status, sim_time, susceptible, exposed, infected,
                 recovered, input ready);
  modport sink(input valid, status, sim_time, susceptible, exposed, infected,
               recovered, output ready);
endinterface

FILE: rtl/core/seir_cfg_if.sv
// Configuration write channel: register index and write data.
interface seir_cfg_if import seir_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  q16_t                 data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/core/seir_datapath.sv
// Datapath: config registers, model state, shared multiplier and result register.
module seir_datapath import seir_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_cmd_t             cmd,
  output dp_stat_t             stat,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  q16_t                 cfg_data,
  input  logic                 in_kind,
  input  frac_t                in_sus,
  input  frac_t                in_exp,
  input  frac_t                in_inf,
  input  frac_t                in_rec,
  output status_t              out_status,
  output q16_t                 out_time,
  output frac_t                out_sus,
  output frac_t                out_exp,
  output frac_t                out_inf,
  output frac_t                out_rec
);

  q16_t beta, sigma, gamma, tstep, tend;
  frac_t sus_val, exp_val, inf_val, rec_val;
  q16_t time_val;
  logic loaded;

  frac_t t1, se, gi, ds, de, di;
  logic signed [PROD_W-1:0] prod;
  logic signed [32:0] opa, opb;
  frac_t m16, m30;

  status_t pend_status;
  logic    pend_zero;

  logic signed [34:0] diff;
  logic sum_bad, step_big;
  logic [32:0] tsum;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      beta  <= RST_INFECT_RATE;
      sigma <= RST_INCUBATION_RATE;
      gamma <= RST_RECOVERY_RATE;
      tstep <= RST_TIME_STEP;
      tend  <= RST_END_TIME;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INFECT_RATE:     beta  <= cfg_data;
        REG_INCUBATION_RATE: sigma <= cfg_data;
        REG_RECOVERY_RATE:   gamma <= cfg_data;
        REG_TIME_STEP:       tstep <= cfg_data;
        REG_END_TIME:        tend  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Load checks and tick classification
  always_comb begin
    diff     = 35'(in_sus) + 35'(in_exp) + 35'(in_inf) + 35'(in_rec) - ONE_Q30;
    sum_bad  = (diff > TOL_Q30) || (diff < -TOL_Q30);
    step_big = tstep > tend;
    stat.go_calc = (in_kind == KIND_TICK) && loaded && (time_val < tend);
  end

  // Shared multiplier operand select
  always_comb begin
    unique case (cmd.step_idx)
      ISS_I_BETA:  begin opa = 33'(inf_val); opb = $signed({1'b0, beta});  end
      ISS_E_SIGMA: begin opa = 33'(exp_val); opb = $signed({1'b0, sigma}); end
      ISS_I_GAMMA: begin opa = 33'(inf_val); opb = $signed({1'b0, gamma}); end
      ISS_T1_S:    begin opa = 33'(t1);      opb = 33'(sus_val);           end
      ISS_DR:      begin opa = 33'(gi);      opb = $signed({1'b0, tstep}); end
      ISS_DI:      begin opa = 33'(di);      opb = $signed({1'b0, tstep}); end
      ISS_DS:      begin opa = 33'(ds);      opb = $signed({1'b0, tstep}); end
      ISS_DE:      begin opa = 33'(de);      opb = $signed({1'b0, tstep}); end
      default:     begin opa = '0;           opb = '0;                     end
    endcase
  end

  // Scaled products: rate products drop 16 bits, fraction products 30
  always_comb begin
    m16  = sat_pop(prod >>> 16);
    m30  = sat_pop(prod >>> 30);
    tsum = {1'b0, time_val} + {1'b0, tstep};
  end

  // Model state
  always_ff @(posedge clk) begin
    if (rst) begin
      sus_val  <= '0;
      exp_val  <= '0;
      inf_val  <= '0;
      rec_val  <= '0;
      time_val <= '0;
      loaded   <= 1'b0;
    end else if (cmd.accept) begin
      if (in_kind == KIND_LOAD) begin
        if (sum_bad || step_big) begin
          loaded <= 1'b0;
        end else begin
          sus_val  <= in_sus;
          exp_val  <= in_exp;
          inf_val  <= in_inf;
          rec_val  <= in_rec;
          time_val <= '0;
          loaded   <= 1'b1;
        end
      end
    end else if (cmd.calc) begin
      unique case (cmd.step_idx)
        WB_REC: rec_val <= sat_pop(66'(rec_val) + 66'(m16));
        WB_INF: inf_val <= sat_pop(66'(inf_val) + 66'(m16));
        WB_SUS: sus_val <= sat_pop(66'(sus_val) + 66'(m16));
        WB_EXP: begin
          exp_val  <= sat_pop(66'(exp_val) + 66'(m16));
          time_val <= tsum[32] ? '1 : tsum[31:0];
        end
        default: ;
      endcase
    end
  end

  // Multiplier, intermediate terms and pending row status
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (in_kind == KIND_LOAD) begin
        priority if (sum_bad) begin
          pend_status <= ST_BAD_SUM;
          pend_zero   <= 1'b1;
        end else if (step_big) begin
          pend_status <= ST_STEP_BIG;
          pend_zero   <= 1'b1;
        end else begin
          pend_status <= ST_OK;
          pend_zero   <= 1'b0;
        end
      end else begin
        priority if (!loaded) begin
          pend_status <= ST_NOT_LOADED;
          pend_zero   <= 1'b1;
        end else if (time_val >= tend) begin
          pend_status <= ST_FINISHED;
          pend_zero   <= 1'b0;
        end else begin
          pend_status <= ST_OK;
          pend_zero   <= 1'b0;
        end
      end
    end
    if (cmd.calc) begin
      prod <= opa * opb;
      unique case (cmd.step_idx)
        WB_T1: t1 <= m16;
        WB_SE: se <= m16;
        WB_GI: begin
          gi <= m16;
          di <= sat_pop(66'(se) - 66'(m16));
        end
        WB_BIS: begin
          ds <= sat_pop(-66'(m30));
          de <= sat_pop(66'(m30) - 66'(se));
        end
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= pend_status;
      out_time   <= pend_zero ? '0 : time_val;
      out_sus    <= pend_zero ? '0 : sus_val;
      out_exp    <= pend_zero ? '0 : exp_val;
      out_inf    <= pend_zero ? '0 : inf_val;
      out_rec    <= pend_zero ? '0 : rec_val;
    end
  end

endmodule

FILE: rtl/core/seir_ctrl.sv
// Controller: item acceptance, step sequencer and result handoff.
module seir_ctrl import seir_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_CALC = 3'b010,
    C_EMIT = 3'b100
  } ctl_state_t;

  ctl_state_t state, state_next;
  logic [STEP_W-1:0] step_idx, step_idx_next;
  logic slot_free;

  always_comb begin
    slot_free    = !out_valid || out_ready;
    in_ready     = (state == C_IDLE);
    cmd.accept   = (state == C_IDLE) && in_valid;
    cmd.calc     = (state == C_CALC);
    cmd.emit     = (state == C_EMIT) && slot_free;
    cmd.step_idx = step_idx;
  end

  // Next state
  always_comb begin
    state_next    = state;
    step_idx_next = step_idx;
    unique case (state)
      C_IDLE: begin
        step_idx_next = '0;
        if (in_valid) begin
          state_next = stat.go_calc ? C_CALC : C_EMIT;
        end
      end
      C_CALC: begin
        step_idx_next = step_idx + 1'b1;
        if (step_idx == STEP_LAST) begin
          state_next = C_EMIT;
        end
      end
      C_EMIT: begin
        if (slot_free) begin
          state_next = C_IDLE;
        end
      end
      default: state_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= C_IDLE;
      step_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      step_idx <= step_idx_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/seir_euler_step_core.sv
// Top level of the SEIR forward Euler step core.
//
// Channels: item (sink) takes a load or tick transaction, result (source)
// returns exactly one row per item, cfg (sink) writes the five rate/time
// registers and is always ready. Writes are to go in only while the core
// is idle; the core itself does not enforce this. A load transaction
// resolves at acceptance; its row goes straight to the emit state. A tick
// transaction runs through the step sequencer: eight multiplications share
// one 33x33 multiplier, one issued per cycle with writeback the cycle after,
// and its row goes to the emit state after the last writeback. One item is
// in flight at a time; the next item is accepted the cycle after the row is
// loaded into the result register.
// If the receiver stalls, the row stays in the result register; a new item
// is still accepted and worked on, and its row waits until the register frees.
// Reset (rst, synchronous) restores the register defaults, clears the model
// state to not loaded and drops result valid.
module seir_euler_step_core import seir_pkg::*; (
  input logic        clk,
  input logic        rst,
  seir_item_if.sink    item,
  seir_result_if.source result,
  seir_cfg_if.sink     cfg
);

  ctl_cmd_t cmd;
  dp_stat_t stat;
  status_t  row_status;

  assign cfg.ready     = 1'b1;
  assign result.status = row_status;

  seir_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  seir_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .in_kind    (item.kind),
    .in_sus     (item.init_susceptible),
    .in_exp     (item.init_exposed),
    .in_inf     (item.init_infected),
    .in_rec     (item.init_recovered),
    .out_status (row_status),
    .out_time   (result.sim_time),
    .out_sus    (result.susceptible),
    .out_exp    (result.exposed),
    .out_inf    (result.infected),
    .out_rec    (result.recovered)
  );

`ifndef SYNTHESIS
  // One item at a time: ready drops right after an accepted transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> !item.ready)
    else $error("item accepted while previous item still in flight");

  // A row is only loaded when the result register is free
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!result.valid || result.ready))
    else $error("result row overwritten before it was taken");

  // A runnable tick enters the step sequencer
  a_tick_runs: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && stat.go_calc) |=> cmd.calc)
    else $error("runnable tick did not start the sequencer");

  // Rejected loads and early ticks return an all-zero row
  a_zero_row: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.status == ST_BAD_SUM || result.status == ST_STEP_BIG ||
                      result.status == ST_NOT_LOADED))
    |-> (result.sim_time == '0 && result.susceptible == '0 && result.exposed == '0 &&
         result.infected == '0 && result.recovered == '0))
    else $error("error row carries nonzero fields");
`endif

endmodule

FILE: verif/seir_step_checker.sv
// Row checker for the SEIR Euler step core: predicts each result row and compares it.
module seir_step_checker import seir_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  seir_item_if   item,
  seir_result_if result,
  seir_cfg_if    cfg,
  output int     fail_count,
  output int     outstanding,
  output int     ok_rows,
  output int     rejected_loads,
  output int     finished_rows,
  output int     unloaded_ticks
);

  localparam int     REPORT_LIMIT = 10;
  localparam longint FRAC_MAX     = (longint'(1) <<< (POP_BITS - 1)) - 1;
  localparam longint FRAC_MIN     = -FRAC_MAX - 1;

  typedef struct packed {
    status_t status;
    q16_t    sim_time;
    frac_t   susceptible;
    frac_t   exposed;
    frac_t   infected;
    frac_t   recovered;
  } seir_row_t;

  // Shadow registers and epidemic state
  q16_t  rate_beta, rate_sigma, rate_gamma, step_dt, t_end;
  frac_t s_now, e_now, i_now, r_now;
  q16_t  t_now;
  logic  loaded;

  seir_row_t pending_rows[$];
  int        fails, n_ok, n_rej, n_fin, n_unl;

  function automatic frac_t clamp_frac(input longint v);
    if (v > FRAC_MAX) return frac_t'(FRAC_MAX);
    if (v < FRAC_MIN) return frac_t'(FRAC_MIN);
    return frac_t'(v);
  endfunction

  // Fraction times Q16.16, floor shift by 16
  function automatic frac_t scale_q16(input frac_t a, input q16_t k);
    return clamp_frac((longint'(a) * longint'(k)) >>> 16);
  endfunction

  // Fraction times fraction, floor shift by 30
  function automatic frac_t frac_mul(input frac_t a, input frac_t b);
    return clamp_frac((longint'(a) * longint'(b)) >>> 30);
  endfunction

  function automatic seir_row_t make_row(input status_t st, input q16_t t, input frac_t s,
                                         input frac_t e, input frac_t i, input frac_t r);
    seir_row_t row;
    row.status      = st;
    row.sim_time    = t;
    row.susceptible = s;
    row.exposed     = e;
    row.infected    = i;
    row.recovered   = r;
    return row;
  endfunction

  function automatic string row_text(input seir_row_t r);
    return $sformatf("st=%0d t=%h S=%h E=%h I=%h R=%h", r.status, r.sim_time,
                     r.susceptible, r.exposed, r.infected, r.recovered);
  endfunction

  // One item through the epidemic model; updates the shadow state
  task automatic predict_row(input logic kind, input frac_t s0, input frac_t e0,
                             input frac_t i0, input frac_t r0, output seir_row_t row);
    longint      sum_err;
    frac_t       bis, se, gi, d_s, d_e, d_i;
    logic [32:0] t_sum;
    row = make_row(ST_OK, '0, '0, '0, '0, '0);
    if (kind == KIND_LOAD) begin
      sum_err = longint'(s0) + longint'(e0) + longint'(i0) + longint'(r0)
                - longint'(ONE_Q30);
      if (sum_err > longint'(TOL_Q30) || sum_err < -longint'(TOL_Q30)) begin
        loaded     = 1'b0;
        row.status = ST_BAD_SUM;
      end else if (step_dt > t_end) begin
        loaded     = 1'b0;
        row.status = ST_STEP_BIG;
      end else begin
        s_now  = s0;
        e_now  = e0;
        i_now  = i0;
        r_now  = r0;
        t_now  = '0;
        loaded = 1'b1;
        row    = make_row(ST_OK, '0, s0, e0, i0, r0);
      end
    end else if (!loaded) begin
      row.status = ST_NOT_LOADED;
    end else if (t_now >= t_end) begin
      row = make_row(ST_FINISHED, t_now, s_now, e_now, i_now, r_now);
    end else begin
      // Derivatives from the old state, then one Euler step
      bis   = frac_mul(scale_q16(i_now, rate_beta), s_now);
      se    = scale_q16(e_now, rate_sigma);
      gi    = scale_q16(i_now, rate_gamma);
      d_s   = clamp_frac(-longint'(bis));
      d_e   = clamp_frac(longint'(bis) - longint'(se));
      d_i   = clamp_frac(longint'(se) - longint'(gi));
      s_now = clamp_frac(longint'(s_now) + longint'(scale_q16(d_s, step_dt)));
      e_now = clamp_frac(longint'(e_now) + longint'(scale_q16(d_e, step_dt)));
      i_now = clamp_frac(longint'(i_now) + longint'(scale_q16(d_i, step_dt)));
      r_now = clamp_frac(longint'(r_now) + longint'(scale_q16(gi, step_dt)));
      t_sum = {1'b0, t_now} + {1'b0, step_dt};
      t_now = t_sum[32] ? '1 : t_sum[31:0];
      row   = make_row(ST_OK, t_now, s_now, e_now, i_now, r_now);
    end
  endtask

  // Watch all three channels on each edge
  always @(posedge clk) begin : watch
    seir_row_t want, got;
    if (rst) begin
      rate_beta  = RST_INFECT_RATE;
      rate_sigma = RST_INCUBATION_RATE;
      rate_gamma = RST_RECOVERY_RATE;
      step_dt    = RST_TIME_STEP;
      t_end      = RST_END_TIME;
      s_now      = '0;
      e_now      = '0;
      i_now      = '0;
      r_now      = '0;
      t_now      = '0;
      loaded     = 1'b0;
      pending_rows.delete();
    end else begin
      // Register write transaction
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_INFECT_RATE:     rate_beta  = cfg.data;
          REG_INCUBATION_RATE: rate_sigma = cfg.data;
          REG_RECOVERY_RATE:   rate_gamma = cfg.data;
          REG_TIME_STEP:       step_dt    = cfg.data;
          REG_END_TIME:        t_end      = cfg.data;
          default: ;
        endcase
      end
      // Item transaction: queue the predicted row
      if (item.valid && item.ready) begin
        predict_row(item.kind, item.init_susceptible, item.init_exposed,
                    item.init_infected, item.init_recovered, want);
        pending_rows.push_back(want);
        case (want.status)
          ST_OK:                    n_ok++;
          ST_BAD_SUM, ST_STEP_BIG:  n_rej++;
          ST_FINISHED:              n_fin++;
          default:                  n_unl++;
        endcase
      end
      // Result transaction: compare against the oldest prediction
      if (result.valid && result.ready) begin
        got = make_row(status_t'(result.status), result.sim_time, result.susceptible,
                       result.exposed, result.infected, result.recovered);
        if (pending_rows.size() == 0) begin
          if (fails < REPORT_LIMIT)
            $display("[%0t] unexpected row: %s", $time, row_text(got));
          fails++;
        end else begin
          want = pending_rows.pop_front();
          if (got !== want) begin
            if (fails < REPORT_LIMIT) begin
              $display("[%0t] row mismatch", $time);
              $display("  expected %s", row_text(want));
              $display("  actual   %s", row_text(got));
            end
            fails++;
          end
        end
      end
    end
    fail_count     <= fails;
    outstanding    <= pending_rows.size();
    ok_rows        <= n_ok;
    rejected_loads <= n_rej;
    finished_rows  <= n_fin;
    unloaded_ticks <= n_unl;
  end

endmodule

FILE: verif/tb_seir_euler_step_core.sv
// Testbench top for the SEIR Euler step core: stimulus, flow control and verdict.
module tb_seir_euler_step_core;
  import seir_pkg::*;

  localparam int     ITEM_TARGET  = 1200;
  localparam int     CYCLE_LIMIT  = 500000;
  localparam int     DRAIN_CYCLES = 24;
  localparam int     MAX_GAP      = 8;
  localparam frac_t  FRAC_ONE     = frac_t'(ONE_Q30);
  localparam frac_t  HALF_ONE     = 32'sh2000_0000;
  localparam longint SUM_TOL      = longint'(TOL_Q30);
  localparam q16_t   Q16_ONE      = 32'h0001_0000;
  localparam q16_t   RATE_SPAN    = 32'h0002_0000;
  localparam int     IDX_TOP      = (1 << CFG_IDX_W) - 1;

  logic clk;
  logic rst;

  seir_item_if   item_ch();
  seir_result_if result_ch();
  seir_cfg_if    cfg_ch();

  int fail_count, outstanding, ok_rows, rejected_loads, finished_rows, unloaded_ticks;
  int items_sent;
  int settings_used;
  int cycle_count;
  bit tx_calm;
  bit rx_calm;

  seir_euler_step_core uut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  seir_step_checker row_check (
    .clk           (clk),
    .rst           (rst),
    .item          (item_ch),
    .result        (result_ch),
    .cfg           (cfg_ch),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .ok_rows       (ok_rows),
    .rejected_loads(rejected_loads),
    .finished_rows (finished_rows),
    .unloaded_ticks(unloaded_ticks)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows still expected", cycle_count, outstanding);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result receiver with random stalls
  initial begin
    int stall;
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  // Drive one item; valid stays high after acceptance for a back-to-back follower
  task automatic send_item(input logic kind, input frac_t s0, input frac_t e0,
                           input frac_t i0, input frac_t r0);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid            <= 1'b1;
    item_ch.kind             <= kind;
    item_ch.init_susceptible <= s0;
    item_ch.init_exposed     <= e0;
    item_ch.init_infected    <= i0;
    item_ch.init_recovered   <= r0;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
  endtask

  // Tick with junk in the unused fraction fields
  task automatic send_tick();
    send_item(KIND_TICK, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Load whose fractions sum to 1.0 plus the given slack
  task automatic send_good_load(input longint slack);
    frac_t  e0, i0, r0;
    longint s_full;
    if ($urandom_range(0, 7) == 0) begin
      // wide spread, negatives included; may wrap into a bad sum
      e0 = frac_t'($urandom_range(0, 32'h4000_0000)) - HALF_ONE;
      i0 = frac_t'($urandom_range(0, 32'h4000_0000)) - HALF_ONE;
      r0 = frac_t'($urandom_range(0, 32'h4000_0000)) - HALF_ONE;
    end else begin
      e0 = $urandom_range(0, 32'h1000_0000);
      i0 = $urandom_range(0, 32'h1000_0000);
      r0 = $urandom_range(0, 32'h1000_0000);
    end
    s_full = longint'(FRAC_ONE) - e0 - i0 - r0 + slack;
    send_item(KIND_LOAD, frac_t'(s_full), e0, i0, r0);
  endtask

  // Sum error for a load: mostly inside tolerance, sometimes right on or past its edges
  function automatic longint pick_slack();
    case ($urandom_range(0, 19))
      0:       return SUM_TOL + 1;
      1:       return -(SUM_TOL + 1);
      2:       return SUM_TOL;
      3:       return -SUM_TOL;
      4, 5, 6: return 0;
      default: return longint'($urandom_range(0, 2 * TOL_Q30)) - SUM_TOL;
    endcase
  endfunction

  // Stop feeding items and wait for every expected row
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write all five registers while idle, sometimes with a write to an unused index
  task automatic program_regs(input q16_t beta, input q16_t sigma, input q16_t gamma,
                              input q16_t dt, input q16_t t_end);
    logic [CFG_IDX_W-1:0] idx [6];
    q16_t                 val [6];
    int                   n;
    idx[0] = REG_INFECT_RATE;     val[0] = beta;
    idx[1] = REG_INCUBATION_RATE; val[1] = sigma;
    idx[2] = REG_RECOVERY_RATE;   val[2] = gamma;
    idx[3] = REG_TIME_STEP;       val[3] = dt;
    idx[4] = REG_END_TIME;        val[4] = t_end;
    n = 5;
    if ($urandom_range(0, 2) == 0) begin
      idx[5] = CFG_IDX_W'($urandom_range(REG_END_TIME + 1, IDX_TOP));
      val[5] = $urandom;
      n = 6;
    end
    wait_drained();
    for (int k = 0; k < n; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[k];
      cfg_ch.data  <= val[k];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // Random traffic: mostly load-then-run episodes, plus junk loads and stray ticks
  task automatic run_random_phase(input int n_items);
    int stop_at, pick, n_ticks;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        send_good_load(pick_slack());
        n_ticks = $urandom_range(0, 24);
        repeat (n_ticks) send_tick();
      end else if (pick < 90) begin
        send_item(KIND_LOAD, $urandom, $urandom, $urandom, $urandom);
      end else begin
        send_tick();
      end
    end
  endtask

  // Main sequence
  initial begin
    int   mode, random_start;
    q16_t beta, sigma, gamma, dt, t_end;
    items_sent    = 0;
    settings_used = 0;
    cycle_count   = 0;
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    rst                      <= 1'b1;
    item_ch.valid            <= 1'b0;
    item_ch.kind             <= KIND_LOAD;
    item_ch.init_susceptible <= '0;
    item_ch.init_exposed     <= '0;
    item_ch.init_infected    <= '0;
    item_ch.init_recovered   <= '0;
    cfg_ch.valid             <= 1'b0;
    cfg_ch.index             <= REG_INFECT_RATE;
    cfg_ch.data              <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: tick before load, tolerance edges, extreme fractions
    send_tick();
    send_item(KIND_LOAD, FRAC_ONE - 32'sh0200_0000, 32'sh0100_0000, 32'sh0100_0000, '0);
    send_tick();
    send_tick();
    send_good_load(SUM_TOL);
    send_good_load(SUM_TOL + 1);
    send_tick();
    send_good_load(-(SUM_TOL + 1));
    send_good_load(-SUM_TOL);
    send_item(KIND_LOAD, 32'sh7FFF_FFFF, 32'sh8000_0000, FRAC_ONE, 32'sh0000_0001);
    send_tick();

    // Maximum rates: saturation, then run past the end time
    program_regs('1, '1, '1, Q16_ONE, 3 * Q16_ONE);
    send_item(KIND_LOAD, 32'sh7FFF_FFFF, 32'sh8000_0000, FRAC_ONE, 32'sh0000_0001);
    repeat (4) send_tick();

    // Step larger than end time: load refused, model unloaded
    program_regs('1, '1, '1, 5 * Q16_ONE, Q16_ONE);
    send_good_load(0);
    send_tick();

    // Zero rates and zero step: time stands still
    program_regs('0, '0, '0, '0, 32'h0000_0001);
    send_good_load(0);
    send_tick();
    send_tick();

    // Huge step: time saturates, then finished
    program_regs(RST_INFECT_RATE, RST_INCUBATION_RATE, RST_RECOVERY_RATE,
                 32'hC000_0000, '1);
    send_good_load(0);
    repeat (3) send_tick();

    // Random settings, each followed by a batch of random traffic
    random_start = items_sent;
    while (items_sent - random_start < ITEM_TARGET) begin
      beta  = $urandom_range(0, RATE_SPAN);
      sigma = $urandom_range(0, RATE_SPAN);
      gamma = $urandom_range(0, RATE_SPAN);
      dt    = $urandom_range(32'h0000_0100, Q16_ONE);
      t_end = dt * $urandom_range(1, 24);
      mode  = $urandom_range(0, 9);
      case (mode)
        0: begin
          beta  = $urandom;
          sigma = $urandom;
          gamma = $urandom;
        end
        1: dt = '0;
        2: t_end = $urandom_range(0, dt - 1);
        3: begin
          dt    = $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
          t_end = '1;
        end
        4: begin
          dt    = '0;
          t_end = '0;
        end
        5: begin
          beta  = RST_INFECT_RATE;
          sigma = RST_INCUBATION_RATE;
          gamma = RST_RECOVERY_RATE;
          dt    = RST_TIME_STEP;
          t_end = RST_END_TIME;
        end
        default: ;
      endcase
      program_regs(beta, sigma, gamma, dt, t_end);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      run_random_phase($urandom_range(30, 90));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items over %0d register settings in %0d cycles", items_sent,
             settings_used + 1, cycle_count);
    $display("rows: %0d ok, %0d rejected loads, %0d finished, %0d before load; %0d errors",
             ok_rows, rejected_loads, finished_rows, unloaded_ticks, fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/seir_pkg.sv
rtl/core/seir_item_if.sv
rtl/core/seir_result_if.sv
rtl/core/seir_cfg_if.sv
rtl/core/seir_datapath.sv
rtl/core/seir_ctrl.sv
rtl/core/seir_euler_step_core.sv
verif/seir_step_checker.sv
verif/tb_seir_euler_step_core.sv
